>>> hdl/qccr_pkg.sv
// ----------------------------------------------------------------------------
// qccr_pkg
// Shared types, widths and the reconstruction function of the cosine-aware
// code refinement block.
// ----------------------------------------------------------------------------
`default_nettype none

package qccr_pkg;

    // field and datapath widths
    localparam int ORIG_W  = 16;
    localparam int CODE_W  = 8;
    localparam int BITS_W  = 4;
    localparam int RANGE_W = 16;
    localparam int IDX_W   = 6;
    localparam int CHG_W   = 14;
    localparam int RND_W   = 8;
    localparam int REC_W   = 25;   // reconstruction, value times 2^23
    localparam int DOT_W   = 47;   // signed dot product
    localparam int MAG_W   = 46;   // dot product magnitude
    localparam int NORM_W  = 54;   // reconstruction squared norm
    localparam int ONRM_W  = 40;   // original squared norm
    localparam int SQ_W    = 92;   // squared dot product
    localparam int PROD_W  = 146;  // squared dot product times norm

    localparam logic [BITS_W-1:0] BITS_MAX = 4'd8;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RECON_BASE,
        OP_PROD_BASE,
        OP_LOAD_ACC,
        OP_READ,
        OP_INIT,
        OP_CAND,
        OP_RECON_CAND,
        OP_PROD_CAND,
        OP_DELTA,
        OP_TAKE,
        OP_MUL_SQ1,
        OP_MUL_P1,
        OP_MUL_SQ0,
        OP_MUL_P0
    } t_op;

    // commit shares the write port, so it gets its own flag
    typedef struct packed {
        t_op  op;
        logic commit;
        logic cand_dn;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic c_at_max;
        logic c_zero;
        logic nn_pos;
        logic have;
        logic sgn_diff;
        logic sgn_better;
        logic both_zero;
        logic cmp_better;
        logic mul_done;
        logic changed;
        logic range_nz;
        logic onorm_nz;
    } t_stat;

    // range*(2c+1-2^b)*2^(8-b), zero when not coded
    function automatic logic signed [REC_W-1:0] recon(
        input logic [CODE_W-1:0]  code,
        input logic [BITS_W-1:0]  b,
        input logic [RANGE_W-1:0] rng
    );
        logic signed [10:0] k;
        logic signed [27:0] kr;
        logic signed [27:0] sh;
        k  = signed'({2'b00, code, 1'b1}) - signed'(11'(11'd1 << b));
        kr = k * signed'({1'b0, rng});
        sh = kr <<< (BITS_MAX - b);
        if (b == '0) begin
            return '0;
        end
        return REC_W'(sh);
    endfunction

endpackage

`default_nettype wire

>>> hdl/qccr_mul.sv
// ----------------------------------------------------------------------------
// qccr_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early when the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qccr_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [qccr_pkg::SQ_W-1:0]  i_a,
    input  wire logic [qccr_pkg::NORM_W-1:0] i_b,
    output logic                            o_done,
    output logic [qccr_pkg::PROD_W-1:0]     o_p
);
    import qccr_pkg::*;

    logic                r_busy;
    logic [PROD_W-1:0]   r_a;
    logic [NORM_W-1:0]   r_b;
    logic [PROD_W-1:0]   r_acc;

    // one bit of the multiplier per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_a    <= PROD_W'(i_a);
            r_b    <= i_b;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_acc;

endmodule

`default_nettype wire

>>> hdl/qccr_dp.sv
// ----------------------------------------------------------------------------
// qccr_dp
// Datapath: vector stores, running dot product and norms, candidate
// evaluation and the exact cosine comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module qccr_dp #(
    parameter int MAX_DIMS = 64,
    parameter int AW       = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire qccr_pkg::t_cmd                i_cmd,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic signed [qccr_pkg::ORIG_W-1:0] i_orig_value,
    input  wire logic [qccr_pkg::CODE_W-1:0]   i_start_code,
    input  wire logic [qccr_pkg::BITS_W-1:0]   i_dim_bits,
    input  wire logic [qccr_pkg::RANGE_W-1:0]  i_range_max,
    output qccr_pkg::t_stat                    o_stat,
    output logic [qccr_pkg::CODE_W-1:0]        o_code
);
    import qccr_pkg::*;

    // vector stores
    logic signed [ORIG_W-1:0] r_orig_mem [MAX_DIMS];
    logic [CODE_W-1:0]        r_code_mem [MAX_DIMS];
    logic [BITS_W-1:0]        r_bits_mem [MAX_DIMS];

    logic signed [ORIG_W-1:0] r_wx;
    logic [CODE_W-1:0]        r_wc;
    logic [BITS_W-1:0]        r_wb;
    logic [RANGE_W-1:0]       r_range;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_norm;
    logic [ONRM_W-1:0]        r_onorm;
    logic signed [REC_W-1:0]  r_rr;
    logic signed [DOT_W-1:0]  r_xr0;
    logic [NORM_W-1:0]        r_rq0;
    logic signed [DOT_W-1:0]  r_xrn;
    logic [NORM_W-1:0]        r_rqn;
    logic [CODE_W-1:0]        r_nc;
    logic signed [DOT_W-1:0]  r_dn;
    logic [NORM_W-1:0]        r_nn;
    logic [CODE_W-1:0]        r_bestc;
    logic signed [DOT_W-1:0]  r_bd;
    logic [NORM_W-1:0]        r_bn;
    logic                     r_have;
    logic [SQ_W-1:0]          r_sq;
    logic [PROD_W-1:0]        r_pq;
    t_op                      r_msel;

    logic [BITS_W-1:0]        in_b;
    logic [CODE_W-1:0]        in_c;
    logic [CODE_W-1:0]        maxc;
    logic signed [31:0]       xx_w;
    logic signed [40:0]       xr_w;
    logic signed [49:0]       rsq_w;
    logic [MAG_W-1:0]         dn_mag;
    logic [MAG_W-1:0]         bd_mag;
    logic                     mul_start;
    logic [SQ_W-1:0]          mul_a;
    logic [NORM_W-1:0]        mul_b;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_p;

    // input sanitizing: saturate bits, mask code
    always_comb begin
        in_b = (i_dim_bits > BITS_MAX) ? BITS_MAX : i_dim_bits;
        in_c = i_start_code;
        if (in_b != '0) begin
            in_c = i_start_code & CODE_W'((9'd1 << in_b) - 9'd1);
        end
    end

    assign maxc   = CODE_W'((9'd1 << r_wb) - 9'd1);
    assign xx_w   = i_orig_value * i_orig_value;
    assign xr_w   = r_wx * r_rr;
    assign rsq_w  = r_rr * r_rr;
    assign dn_mag = MAG_W'(r_dn[DOT_W-1] ? -r_dn : r_dn);
    assign bd_mag = MAG_W'(r_bd[DOT_W-1] ? -r_bd : r_bd);

    // multiplier operand select
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (i_cmd.op)
            OP_MUL_SQ1: begin
                mul_start = 1'b1;
                mul_a     = SQ_W'(dn_mag);
                mul_b     = NORM_W'(dn_mag);
            end
            OP_MUL_P1: begin
                mul_start = 1'b1;
                mul_a     = r_sq;
                mul_b     = r_bn;
            end
            OP_MUL_SQ0: begin
                mul_start = 1'b1;
                mul_a     = SQ_W'(bd_mag);
                mul_b     = NORM_W'(bd_mag);
            end
            OP_MUL_P0: begin
                mul_start = 1'b1;
                mul_a     = r_sq;
                mul_b     = r_nn;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    qccr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_orig_mem[i_addr] <= i_orig_value;
            r_code_mem[i_addr] <= in_c;
            r_bits_mem[i_addr] <= in_b;
        end else if (i_cmd.commit && (r_bestc != r_wc)) begin
            r_code_mem[i_addr] <= r_bestc;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_wx <= i_orig_value;
            r_wc <= in_c;
            r_wb <= in_b;
        end else if (i_cmd.op == OP_READ) begin
            r_wx <= r_orig_mem[i_addr];
            r_wc <= r_code_mem[i_addr];
            r_wb <= r_bits_mem[i_addr];
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '0;
            r_dot   <= '0;
            r_norm  <= '0;
            r_onorm <= '0;
        end else if (i_cmd.op == OP_LOAD) begin
            if (i_cmd.first) begin
                r_range <= i_range_max;
                r_dot   <= '0;
                r_norm  <= '0;
                r_onorm <= ONRM_W'(unsigned'(xx_w));
            end else begin
                r_onorm <= r_onorm + ONRM_W'(unsigned'(xx_w));
            end
        end else if (i_cmd.op == OP_LOAD_ACC) begin
            r_dot  <= r_dot + r_xr0;
            r_norm <= r_norm + r_rq0;
        end else if (i_cmd.commit && (r_bestc != r_wc)) begin
            r_dot  <= r_bd;
            r_norm <= r_bn;
        end
    end

    // candidate evaluation steps
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_RECON_BASE: r_rr <= recon(r_wc, r_wb, r_range);
            OP_RECON_CAND: r_rr <= recon(r_nc, r_wb, r_range);
            OP_PROD_BASE: begin
                r_xr0 <= DOT_W'(xr_w);
                r_rq0 <= NORM_W'(unsigned'(rsq_w));
            end
            OP_PROD_CAND: begin
                r_xrn <= DOT_W'(xr_w);
                r_rqn <= NORM_W'(unsigned'(rsq_w));
            end
            OP_CAND: r_nc <= i_cmd.cand_dn ? r_wc - 1'b1 : r_wc + 1'b1;
            OP_DELTA: begin
                r_dn <= r_dot - r_xr0 + r_xrn;
                r_nn <= r_norm - r_rq0 + r_rqn;
            end
            OP_INIT: begin
                r_bestc <= r_wc;
                r_bd    <= r_dot;
                r_bn    <= r_norm;
                r_have  <= (r_norm != '0);
            end
            OP_TAKE: begin
                r_bestc <= r_nc;
                r_bd    <= r_dn;
                r_bn    <= r_nn;
                r_have  <= 1'b1;
            end
            default: begin
            end
        endcase
        // which product is running, and where its result goes
        if (mul_start) begin
            r_msel <= i_cmd.op;
        end
        if (mul_done) begin
            if (r_msel == OP_MUL_SQ1 || r_msel == OP_MUL_SQ0) begin
                r_sq <= SQ_W'(mul_p);
            end else if (r_msel == OP_MUL_P1) begin
                r_pq <= mul_p;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.b_zero     = (r_wb == '0);
        o_stat.c_at_max   = (r_wc >= maxc);
        o_stat.c_zero     = (r_wc == '0);
        o_stat.nn_pos     = (r_nn != '0);
        o_stat.have       = r_have;
        o_stat.sgn_diff   = (r_dn > 0) != (r_bd > 0) || (r_dn < 0) != (r_bd < 0);
        o_stat.sgn_better = (r_dn > 0) || ((r_dn == 0) && (r_bd < 0));
        o_stat.both_zero  = (r_dn == 0) && (r_bd == 0);
        o_stat.cmp_better = (r_dn > 0) ? (r_pq > mul_p) : (r_pq < mul_p);
        o_stat.mul_done   = mul_done;
        o_stat.changed    = (r_bestc != r_wc);
        o_stat.range_nz   = (r_range != '0);
        o_stat.onorm_nz   = (r_onorm != '0);
    end

    assign o_code = r_wc;

endmodule

`default_nettype wire

>>> hdl/qccr_ctrl.sv
// ----------------------------------------------------------------------------
// qccr_ctrl
// Controller: load sequencing, refinement passes, candidate decisions and
// result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qccr_ctrl #(
    parameter int MAX_DIMS = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         i_last_dim,
    input  wire logic                         i_cfg_we,
    input  wire logic [qccr_pkg::RND_W-1:0]   i_cfg_wdata,
    input  wire qccr_pkg::t_stat              i_stat,
    output logic                              busy,
    output qccr_pkg::t_cmd                    o_cmd,
    output logic [AW-1:0]                     o_addr,
    output logic                              o_valid,
    output logic [qccr_pkg::IDX_W-1:0]        o_dim_index,
    output logic [qccr_pkg::CHG_W-1:0]        o_change_total,
    output logic                              o_last_result
);
    import qccr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, L_RECON, L_PROD, L_ACC,
        R_READ, R_INIT, R_RECON, R_PROD,
        C_UP, C_DOWN, C_RECON, C_PROD, C_DELTA, C_DEC, C_CMP, C_TAKE,
        M_SQ1, M_W1, M_P1, M_W2, M_SQ0, M_W3, M_P0, M_W4,
        R_COMMIT, R_NEXT, O_READ, O_EMIT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_load_cnt;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_rc;
    logic [RND_W-1:0]  r_round;
    logic [RND_W-1:0]  r_max_rounds;
    logic [CHG_W-1:0]  r_chg;
    logic              r_last;
    logic              r_down;
    logic              r_valid;
    logic [AW-1:0]     r_oidx;
    logic              r_olast;
    t_state            after_cand;

    assign busy       = (r_state != S_IDLE);
    assign after_cand = r_down ? R_COMMIT : C_DOWN;

    // command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.first   = (r_load_cnt == '0);
        o_cmd.cand_dn = (r_state == C_DOWN);
        o_addr        = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_addr   = r_load_cnt[AW-1:0];
                o_cmd.op = start ? OP_LOAD : OP_NONE;
            end
            L_RECON, R_RECON: o_cmd.op = OP_RECON_BASE;
            L_PROD, R_PROD:   o_cmd.op = OP_PROD_BASE;
            L_ACC:            o_cmd.op = OP_LOAD_ACC;
            R_READ, O_READ:   o_cmd.op = OP_READ;
            R_INIT:           o_cmd.op = OP_INIT;
            C_UP:             o_cmd.op = i_stat.c_at_max ? OP_NONE : OP_CAND;
            C_DOWN:           o_cmd.op = i_stat.c_zero ? OP_NONE : OP_CAND;
            C_RECON:          o_cmd.op = OP_RECON_CAND;
            C_PROD:           o_cmd.op = OP_PROD_CAND;
            C_DELTA:          o_cmd.op = OP_DELTA;
            C_TAKE:           o_cmd.op = OP_TAKE;
            M_SQ1:            o_cmd.op = OP_MUL_SQ1;
            M_P1:             o_cmd.op = OP_MUL_P1;
            M_SQ0:            o_cmd.op = OP_MUL_SQ0;
            M_P0:             o_cmd.op = OP_MUL_P0;
            R_COMMIT:         o_cmd.commit = 1'b1;
            default:          o_cmd.op = OP_NONE;
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_cnt   <= '0;
            r_chg        <= '0;
            r_max_rounds <= RND_W'(4);
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_rounds <= i_cfg_wdata;
            end
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_last     <= i_last_dim ||
                                      (r_load_cnt == CW'(MAX_DIMS - 1));
                        r_load_cnt <= r_load_cnt + 1'b1;
                        if (r_load_cnt == '0) begin
                            r_chg <= '0;
                        end
                        r_state <= L_RECON;
                    end
                end
                L_RECON: r_state <= L_PROD;
                L_PROD:  r_state <= L_ACC;
                L_ACC: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_n     <= r_load_cnt;
                        r_i     <= '0;
                        r_round <= '0;
                        r_rc    <= '0;
                        if (i_stat.range_nz && i_stat.onorm_nz &&
                            (r_max_rounds != '0)) begin
                            r_state <= R_READ;
                        end else begin
                            r_state <= O_READ;
                        end
                    end
                end
                R_READ: r_state <= R_INIT;
                R_INIT: r_state <= i_stat.b_zero ? R_NEXT : R_RECON;
                R_RECON: r_state <= R_PROD;
                R_PROD:  r_state <= C_UP;
                C_UP: begin
                    r_down  <= 1'b0;
                    r_state <= i_stat.c_at_max ? C_DOWN : C_RECON;
                end
                C_DOWN: begin
                    r_down  <= 1'b1;
                    r_state <= i_stat.c_zero ? R_COMMIT : C_RECON;
                end
                C_RECON: r_state <= C_PROD;
                C_PROD:  r_state <= C_DELTA;
                C_DELTA: r_state <= C_DEC;
                // zero norm loses, no best yet wins, then sign, then magnitude
                C_DEC: begin
                    if (!i_stat.nn_pos) begin
                        r_state <= after_cand;
                    end else if (!i_stat.have) begin
                        r_state <= C_TAKE;
                    end else if (i_stat.sgn_diff) begin
                        r_state <= i_stat.sgn_better ? C_TAKE : after_cand;
                    end else if (i_stat.both_zero) begin
                        r_state <= after_cand;
                    end else begin
                        r_state <= M_SQ1;
                    end
                end
                M_SQ1: r_state <= M_W1;
                M_W1:  r_state <= i_stat.mul_done ? M_P1 : M_W1;
                M_P1:  r_state <= M_W2;
                M_W2:  r_state <= i_stat.mul_done ? M_SQ0 : M_W2;
                M_SQ0: r_state <= M_W3;
                M_W3:  r_state <= i_stat.mul_done ? M_P0 : M_W3;
                M_P0:  r_state <= M_W4;
                M_W4:  r_state <= i_stat.mul_done ? C_CMP : M_W4;
                C_CMP:  r_state <= i_stat.cmp_better ? C_TAKE : after_cand;
                C_TAKE: r_state <= after_cand;
                R_COMMIT: begin
                    if (i_stat.changed) begin
                        r_rc <= r_rc + 1'b1;
                    end
                    r_state <= R_NEXT;
                end
                // end of pass: fold in the change count, stop when quiet or at the round limit
                R_NEXT: begin
                    if (r_i + 1'b1 == r_n) begin
                        r_chg <= r_chg + CHG_W'(r_rc);
                        r_i   <= '0;
                        if ((r_rc == '0) ||
                            ({1'b0, r_round} + 1'b1 == {1'b0, r_max_rounds})) begin
                            r_state <= O_READ;
                        end else begin
                            r_round <= r_round + 1'b1;
                            r_rc    <= '0;
                            r_state <= R_READ;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= R_READ;
                    end
                end
                O_READ: begin
                    r_valid <= 1'b1;
                    r_oidx  <= r_i[AW-1:0];
                    r_olast <= (r_i + 1'b1 == r_n);
                    r_state <= O_EMIT;
                end
                O_EMIT: begin
                    if (r_olast) begin
                        r_load_cnt <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= O_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_dim_index    = IDX_W'(r_oidx);
    assign o_change_total = r_chg;
    assign o_last_result  = r_olast;

endmodule

`default_nettype wire

>>> hdl/quant_code_cosine_refine_core.sv
// ----------------------------------------------------------------------------
// quant_code_cosine_refine_core
// Loads one vector a dimension per beat, refines the quantization codes to
// improve the cosine to the original vector, then emits one code per dimension.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start, busy        i_orig_value, i_start_code, i_dim_bits,
//                               i_range_max, i_last_dim
//  result    o_valid (strobe)   o_refined_code, o_dim_index, o_change_total,
//                               o_last_result
//  config    i_cfg_we           i_cfg_wdata (max_rounds)
//
//  a load beat passes through the reconstruct, product and accumulate states;
//  after the last beat each refinement step reads the dimension and skips an
//  uncoded one; a coded one adds up to two cosine comparisons, each four serial
//  multiplies in the shift-add unit and a compare state.
//  each result is emitted after a registered store read of its code.
//  reset is synchronous; the receiver cannot stall, so no result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module quant_code_cosine_refine_core #(
    parameter int MAX_DIMS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [qccr_pkg::ORIG_W-1:0] i_orig_value,
    input  wire logic [qccr_pkg::CODE_W-1:0]       i_start_code,
    input  wire logic [qccr_pkg::BITS_W-1:0]       i_dim_bits,
    input  wire logic [qccr_pkg::RANGE_W-1:0]      i_range_max,
    input  wire logic                              i_last_dim,
    input  wire logic                              i_cfg_we,
    input  wire logic [qccr_pkg::RND_W-1:0]        i_cfg_wdata,
    output logic                                   o_valid,
    output logic [qccr_pkg::CODE_W-1:0]            o_refined_code,
    output logic [qccr_pkg::IDX_W-1:0]             o_dim_index,
    output logic [qccr_pkg::CHG_W-1:0]             o_change_total,
    output logic                                   o_last_result
);
    import qccr_pkg::*;

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW = $clog2(MAX_DIMS + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] addr;

    qccr_ctrl #(
        .MAX_DIMS (MAX_DIMS),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_last_dim     (i_last_dim),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_stat         (stat),
        .busy           (busy),
        .o_cmd          (cmd),
        .o_addr         (addr),
        .o_valid        (o_valid),
        .o_dim_index    (o_dim_index),
        .o_change_total (o_change_total),
        .o_last_result  (o_last_result)
    );

    qccr_dp #(
        .MAX_DIMS (MAX_DIMS),
        .AW       (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .i_orig_value (i_orig_value),
        .i_start_code (i_start_code),
        .i_dim_bits   (i_dim_bits),
        .i_range_max  (i_range_max),
        .o_stat       (stat),
        .o_code       (o_refined_code)
    );

endmodule

`default_nettype wire
